FILE: sv/linear_interp_audio_resampler_unit_defines.svh
// Assertion macros shared by the resampler RTL.
`ifndef LINEAR_INTERP_AUDIO_RESAMPLER_UNIT_DEFINES_SVH
`define LINEAR_INTERP_AUDIO_RESAMPLER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define LIRES_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("resampler assertion failed");
// Next-cycle implication.
`define LIRES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("resampler assertion failed");
`else
`define LIRES_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LIRES_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/lires_pkg.sv
// Types and constants of the linear interpolation resampler.
package lires_pkg;

    localparam int FADE_FRAMES = 1024;
    localparam int FADE_SHIFT  = $clog2(FADE_FRAMES);
    localparam int FADE_W      = $clog2(FADE_FRAMES + 1);

    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 21;
    localparam int PHASE_W    = 22;
    localparam int GAIN_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam int OPND_W     = SAMPLE_W + 1;
    localparam int PROD_W     = 2 * OPND_W;

    localparam logic [FADE_W-1:0]  FADE_FULL  = FADE_W'(FADE_FRAMES);
    localparam logic [PHASE_W-1:0] ONE_Q16    = PHASE_W'(65536);
    localparam logic [STEP_W-1:0]  MIN_STEP   = STEP_W'(1024);
    localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(65536);
    localparam logic [GAIN_W-1:0]  UNITY_GAIN = GAIN_W'(32767);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP   = 2'd0,
        CFG_STEREO = 2'd1,
        CFG_GAIN   = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FADE,
        ST_SCALE,
        ST_CHECK,
        ST_LERP,
        ST_GAIN,
        ST_LOAD,
        ST_WRAP
    } state_t;

    typedef struct packed {
        logic accept;
        logic fade_mul;
        logic fade_apply;
        logic lerp_mul;
        logic gain_mul;
        logic out_load;
        logic wrap;
    } cmd_t;

    typedef struct packed {
        logic fade_active;
        logic phase_lt_one;
        logic last;
        logic out_free;
    } status_t;

endpackage

FILE: sv/lires_pcm_if.sv
// Input channel: one PCM frame per word.
interface lires_pcm_if import lires_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
    logic                       start_flag;

    modport source (output valid, sample_left, sample_right, start_flag, input ready);
    modport sink (input valid, sample_left, sample_right, start_flag, output ready);
endinterface

FILE: sv/lires_frame_if.sv
// Output channel: one stereo frame per word.
interface lires_frame_if import lires_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       last_of_run;

    modport source (output valid, out_left, out_right, last_of_run, input ready);
    modport sink (input valid, out_left, out_right, last_of_run, output ready);
endinterface

FILE: sv/lires_cfg_if.sv
// Configuration write channel: register index and data.
interface lires_cfg_if import lires_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/lires_ctrl.sv
// Sequencer of the resampler: walks each input frame through fade and output steps.
module lires_ctrl import lires_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pcm_valid,
    input  status_t status,
    output logic    pcm_ready,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pcm_valid)
                begin
                    state_next = ST_FADE;
                end
            end
            ST_FADE:
            begin
                state_next = status.fade_active ? ST_SCALE : ST_CHECK;
            end
            ST_SCALE:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = status.phase_lt_one ? ST_LERP : ST_WRAP;
            end
            ST_LERP:
            begin
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    state_next = status.last ? ST_WRAP : ST_LERP;
                end
            end
            ST_WRAP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        pcm_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pcm_ready  = 1'b1;
                cmd.accept = pcm_valid;
            end
            ST_FADE:
            begin
                cmd.fade_mul = 1'b1;
            end
            ST_SCALE:
            begin
                cmd.fade_apply = 1'b1;
            end
            ST_CHECK:
            begin
            end
            ST_LERP:
            begin
                cmd.lerp_mul = 1'b1;
            end
            ST_GAIN:
            begin
                cmd.gain_mul = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.out_load = status.out_free;
            end
            ST_WRAP:
            begin
                cmd.wrap = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: sv/lires_datapath.sv
// Datapath of the resampler: registers, phase accumulator, multipliers, output word.
module lires_datapath import lires_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output status_t                    status,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [SAMPLE_W-1:0] sample_left,
    input  logic signed [SAMPLE_W-1:0] sample_right,
    input  logic                       start_flag,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] out_left,
    output logic signed [SAMPLE_W-1:0] out_right,
    output logic                       last_of_run
);

    logic [STEP_W-1:0]          step_reg;
    logic                       stereo_reg;
    logic [GAIN_W-1:0]          gain_reg;

    logic [PHASE_W-1:0]         phase_reg;
    logic signed [SAMPLE_W-1:0] held_l_reg;
    logic signed [SAMPLE_W-1:0] held_r_reg;
    logic [FADE_W-1:0]          fade_cnt_reg;

    logic signed [SAMPLE_W-1:0] cur_l_reg;
    logic signed [SAMPLE_W-1:0] cur_r_reg;
    logic signed [PROD_W-1:0]   mult_l_reg;
    logic signed [PROD_W-1:0]   mult_r_reg;
    logic signed [SAMPLE_W-1:0] val_l_reg;
    logic signed [SAMPLE_W-1:0] val_r_reg;
    logic                       last_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_l_reg;
    logic signed [SAMPLE_W-1:0] out_r_reg;
    logic                       out_last_reg;

    logic [STEP_W-1:0]          step_eff;
    logic [PHASE_W-1:0]         phase_sum;
    logic [FADE_W-1:0]          fade_gain;
    logic signed [SAMPLE_W-1:0] lerp_l;
    logic signed [SAMPLE_W-1:0] lerp_r;
    logic signed [OPND_W-1:0]   op_a_l;
    logic signed [OPND_W-1:0]   op_a_r;
    logic signed [OPND_W-1:0]   op_b;
    logic signed [PROD_W-1:0]   prod_l;
    logic signed [PROD_W-1:0]   prod_r;
    logic signed [PROD_W-1:0]   bias_l;
    logic signed [PROD_W-1:0]   bias_r;
    logic signed [PROD_W-1:0]   faded_l;
    logic signed [PROD_W-1:0]   faded_r;
    logic signed [SAMPLE_W-1:0] gained_l;
    logic signed [SAMPLE_W-1:0] gained_r;
    logic                       unity;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_RESET;
            stereo_reg <= 1'b0;
            gain_reg   <= UNITY_GAIN;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_STEP:   step_reg   <= cfg_data[STEP_W-1:0];
                CFG_STEREO: stereo_reg <= cfg_data[0];
                CFG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                default:    ;
            endcase
        end
    end

    assign step_eff  = (step_reg < MIN_STEP) ? MIN_STEP : step_reg;
    assign phase_sum = phase_reg + PHASE_W'(step_eff);
    assign fade_gain = FADE_FULL - fade_cnt_reg;

    // Interpolated value: held + floor(diff * frac / 2^16); the low 16 bits suffice
    // because the true result lies between held and current.
    assign lerp_l = held_l_reg + mult_l_reg[31:16];
    assign lerp_r = held_r_reg + mult_r_reg[31:16];

    // One shared multiplier per channel, operands chosen by the step in progress.
    always_comb
    begin
        priority if (cmd.fade_mul)
        begin
            op_a_l = OPND_W'(cur_l_reg);
            op_a_r = OPND_W'(cur_r_reg);
            op_b   = signed'(OPND_W'(fade_gain));
        end
        else if (cmd.lerp_mul)
        begin
            op_a_l = OPND_W'(cur_l_reg) - OPND_W'(held_l_reg);
            op_a_r = OPND_W'(cur_r_reg) - OPND_W'(held_r_reg);
            op_b   = signed'({1'b0, phase_reg[15:0]});
        end
        else
        begin
            op_a_l = OPND_W'(lerp_l);
            op_a_r = OPND_W'(lerp_r);
            op_b   = signed'({2'b00, gain_reg});
        end
    end

    assign prod_l = op_a_l * op_b;
    assign prod_r = op_a_r * op_b;

    // Fade division truncates toward zero: negative products get a bias first.
    assign bias_l  = mult_l_reg[PROD_W-1] ? PROD_W'(FADE_FRAMES - 1) : '0;
    assign bias_r  = mult_r_reg[PROD_W-1] ? PROD_W'(FADE_FRAMES - 1) : '0;
    assign faded_l = (mult_l_reg + bias_l) >>> FADE_SHIFT;
    assign faded_r = (mult_r_reg + bias_r) >>> FADE_SHIFT;

    assign unity    = (gain_reg == UNITY_GAIN);
    assign gained_l = unity ? val_l_reg : mult_l_reg[30:15];
    assign gained_r = unity ? val_r_reg : mult_r_reg[30:15];

    // Resampler state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            held_l_reg   <= '0;
            held_r_reg   <= '0;
            fade_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.accept && start_flag)
            begin
                phase_reg    <= '0;
                held_l_reg   <= '0;
                held_r_reg   <= '0;
                fade_cnt_reg <= FADE_FULL;
            end
            if (cmd.fade_apply)
            begin
                fade_cnt_reg <= fade_cnt_reg - FADE_W'(1);
            end
            if (cmd.gain_mul)
            begin
                phase_reg <= phase_sum;
            end
            if (cmd.wrap)
            begin
                phase_reg  <= phase_reg - ONE_Q16;
                held_l_reg <= cur_l_reg;
                held_r_reg <= cur_r_reg;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_l_reg <= sample_left;
            cur_r_reg <= stereo_reg ? sample_right : sample_left;
        end
        if (cmd.fade_apply)
        begin
            cur_l_reg <= faded_l[SAMPLE_W-1:0];
            cur_r_reg <= faded_r[SAMPLE_W-1:0];
        end
        if (cmd.fade_mul || cmd.lerp_mul || cmd.gain_mul)
        begin
            mult_l_reg <= prod_l;
            mult_r_reg <= prod_r;
        end
        if (cmd.gain_mul)
        begin
            val_l_reg <= lerp_l;
            val_r_reg <= lerp_r;
            last_reg  <= (phase_sum >= ONE_Q16);
        end
    end

    // Output word register; the next item may start while it waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_l_reg    <= gained_l;
            out_r_reg    <= gained_r;
            out_last_reg <= last_reg;
        end
    end

    assign status.fade_active  = (fade_cnt_reg != '0);
    assign status.phase_lt_one = (phase_reg < ONE_Q16);
    assign status.last         = last_reg;
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_left    = out_l_reg;
    assign out_right   = out_r_reg;
    assign last_of_run = out_last_reg;

endmodule

FILE: sv/linear_interp_audio_resampler_unit.sv
// Top level of the linear interpolation audio resampler.
//
//  Channel    Dir  Word contents
//  pcm        in   sample_left, sample_right, start_flag
//  resampled  out  out_left, out_right, last_of_run
//  cfg        in   index, data (phase step, stereo select, output gain)
//
// An input frame takes the accept, fade and check steps (and a scale step during
// a fade-in), then the lerp, gain and load steps per output frame, set by the
// shared multiply per channel for lerp, then gain; up to 64 outputs per input frame.
// rst_n clears the state, sets the registers to their defaults and empties the output.
// A stalled output holds the sequencer; the last output of a frame may wait
// in the output register while the next input frame is accepted.
`include "linear_interp_audio_resampler_unit_defines.svh"

module linear_interp_audio_resampler_unit import lires_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lires_pcm_if.sink    pcm,
    lires_frame_if.source resampled,
    lires_cfg_if.sink    cfg
);

    cmd_t    cmd;
    status_t status;
    logic    pcm_ready;

    assign cfg.ready = 1'b1;
    assign pcm.ready = pcm_ready;

    lires_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pcm_valid (pcm.valid),
        .status    (status),
        .pcm_ready (pcm_ready),
        .cmd       (cmd)
    );

    lires_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .sample_left  (pcm.sample_left),
        .sample_right (pcm.sample_right),
        .start_flag   (pcm.start_flag),
        .out_ready    (resampled.ready),
        .out_valid    (resampled.valid),
        .out_left     (resampled.out_left),
        .out_right    (resampled.out_right),
        .last_of_run  (resampled.last_of_run)
    );

    // The sequencer issues at most one step per cycle.
    `LIRES_ASSERT_SAME(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd))
    // Input is only taken while no output step is in flight.
    `LIRES_ASSERT_SAME(a_ready_idle, clk, rst_n, pcm_ready, !(cmd.lerp_mul || cmd.gain_mul || cmd.out_load))
    // Loading the last word of a frame is followed by the phase wrap.
    `LIRES_ASSERT_NEXT(a_last_wraps, clk, rst_n, cmd.out_load && status.last, cmd.wrap)

endmodule

FILE: tb/linear_interp_audio_resampler_unit_test.sv
// Self-checking testbench for the linear interpolation audio resampler.
`timescale 1ns / 1ps

import lires_pkg::*;

// Tracks resampler state and holds the stereo frames that accepted PCM words must produce.
class resampled_frame_book;
    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                last;
    } frame_t;

    localparam int MAX_RUN      = 64;

    logic [STEP_W-1:0] step_word;
    logic              stereo_on;
    logic [GAIN_W-1:0] gain_word;
    int unsigned       phase_acc;
    int                prev_left;
    int                prev_right;
    int                fade_remaining;
    frame_t            frames_due[$];
    int                mismatches;

    function new();
        step_word      = STEP_RESET;
        stereo_on      = 1'b0;
        gain_word      = UNITY_GAIN;
        phase_acc      = 0;
        prev_left      = 0;
        prev_right     = 0;
        fade_remaining = 0;
        mismatches     = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_STEP:   step_word = value[STEP_W-1:0];
            CFG_STEREO: stereo_on = value[0];
            CFG_GAIN:   gain_word = value[GAIN_W-1:0];
            default:    ;
        endcase
    endfunction

    function int fade_in(int sample, int ramp);
        // Signed division truncates toward zero.
        return (sample * ramp) / FADE_FRAMES;
    endfunction

    function int interpolate(int held, int target, int unsigned frac);
        longint span;
        span = longint'(target - held) * longint'(frac);
        return held + int'(span >>> 16);
    endfunction

    function int apply_gain(int v);
        longint scaled;
        if (gain_word == UNITY_GAIN)
            return v;
        scaled = longint'(v) * longint'(gain_word);
        return int'(scaled >>> 15);
    endfunction

    function void take_pcm(logic [SAMPLE_W-1:0] left_in, logic [SAMPLE_W-1:0] right_in,
                           logic start);
        int          cur_left;
        int          cur_right;
        int unsigned stride;
        int          count;
        frame_t      f;
        cur_left  = int'($signed(left_in));
        cur_right = int'($signed(right_in));
        stride    = (step_word < MIN_STEP) ? MIN_STEP : step_word;
        if (start)
        begin
            phase_acc      = 0;
            prev_left      = 0;
            prev_right     = 0;
            fade_remaining = FADE_FRAMES;
        end
        if (!stereo_on)
            cur_right = cur_left;
        if (fade_remaining > 0)
        begin
            cur_left  = fade_in(cur_left, FADE_FRAMES - fade_remaining);
            cur_right = fade_in(cur_right, FADE_FRAMES - fade_remaining);
            fade_remaining--;
        end
        count = 0;
        while (phase_acc < ONE_Q16 && count < MAX_RUN)
        begin
            f.left  = SAMPLE_W'(apply_gain(interpolate(prev_left, cur_left, phase_acc[15:0])));
            f.right = SAMPLE_W'(apply_gain(interpolate(prev_right, cur_right, phase_acc[15:0])));
            f.last  = (phase_acc + stride >= ONE_Q16) || (count == MAX_RUN - 1);
            frames_due.push_back(f);
            count++;
            phase_acc += stride;
        end
        // The held frame only moves on once the phase has crossed a whole input period.
        if (phase_acc >= ONE_Q16)
        begin
            phase_acc  -= ONE_Q16;
            prev_left  = cur_left;
            prev_right = cur_right;
        end
        phase_acc = phase_acc & ((1 << PHASE_W) - 1);
    endfunction

    function void note_mismatch(string field, int want, int got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void match_output(logic [SAMPLE_W-1:0] left_out, logic [SAMPLE_W-1:0] right_out,
                               logic last_out);
        frame_t want;
        if (frames_due.size() == 0)
        begin
            mismatches++;
            $display("%0t: frame mismatch, expected none, actual left %0d right %0d last %0b",
                     $time, $signed(left_out), $signed(right_out), last_out);
            return;
        end
        want = frames_due.pop_front();
        if (want.left !== left_out)
            note_mismatch("out_left", int'($signed(want.left)), int'($signed(left_out)));
        if (want.right !== right_out)
            note_mismatch("out_right", int'($signed(want.right)), int'($signed(right_out)));
        if (want.last !== last_out)
            note_mismatch("last_of_run", int'(want.last), int'(last_out));
    endfunction
endclass

module linear_interp_audio_resampler_unit_test;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES    = 32;
    localparam int LONG_HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n;
    bit   idle_on;
    bit   hold_request;

    resampled_frame_book frame_book = new();

    lires_pcm_if   pcm();
    lires_frame_if resampled();
    lires_cfg_if   cfg();

    linear_interp_audio_resampler_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .pcm(pcm),
        .resampled(resampled),
        .cfg(cfg)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && resampled.valid && resampled.ready)
            frame_book.match_output(resampled.out_left, resampled.out_right,
                                    resampled.last_of_run);
    end

    // Output side: short random stalls while idle_on is set, plus one long hold on request.
    initial
    begin
        int unsigned hold_left;
        hold_left       = 0;
        resampled.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD_CYCLES;
            end
            else if (hold_left == 0 && idle_on && $urandom_range(0, 5) == 0)
                hold_left = $urandom_range(1, 7);
            resampled.ready <= (hold_left == 0);
            if (hold_left != 0)
                hold_left--;
        end
    end

    // Leaves valid high; the caller lowers it or offers the next word.
    task automatic send_frame(input logic [SAMPLE_W-1:0] left_in,
                              input logic [SAMPLE_W-1:0] right_in, input logic start);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            pcm.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        pcm.valid        <= 1'b1;
        pcm.sample_left  <= left_in;
        pcm.sample_right <= right_in;
        pcm.start_flag   <= start;
        @(posedge clk);
        while (!pcm.ready)
            @(posedge clk);
        frame_book.take_pcm(left_in, right_in, start);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        frame_book.set_register(idx, value);
        @(negedge clk);
    endtask

    // A word that yields no frame may still be in flight, hence the extra settle time.
    task automatic drain_and_pause();
        pcm.valid <= 1'b0;
        while (frame_book.frames_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] step_word,
                                  input logic [CFG_DATA_W-1:0] stereo_word,
                                  input logic [CFG_DATA_W-1:0] gain_word);
        drain_and_pause();
        write_register(CFG_STEP, step_word);
        write_register(CFG_STEREO, stereo_word);
        write_register(CFG_GAIN, gain_word);
        write_register(CFG_SPARE, CFG_DATA_W'($urandom));
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return SAMPLE_W'($urandom_range(0, 15) - 8);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return CFG_DATA_W'($urandom_range(0, 1023));
            1:       return CFG_DATA_W'($urandom_range(1024, 4096));
            2:       return CFG_DATA_W'($urandom_range(262144, 2097151));
            default: return CFG_DATA_W'($urandom_range(8000, 140000));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return CFG_DATA_W'($urandom_range(0, 32767));
            1:       return 21'd16384;
            2:       return 21'd32766;
            default: return CFG_DATA_W'(UNITY_GAIN);
        endcase
    endfunction

    // Plays open with a start word when starts are enabled at all.
    task automatic random_play(input int frames, input int start_odds, input bit with_hold);
        logic start;
        apply_settings(with_hold ? 21'd20000 : pick_step(),
                       CFG_DATA_W'($urandom_range(0, 1)), pick_gain());
        if (with_hold)
            hold_request = 1'b1;
        for (int i = 0; i < frames; i++)
        begin
            start = (start_odds != 0) && (i == 0 || $urandom_range(1, start_odds) == 1);
            send_frame(pick_sample(), pick_sample(), start);
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        idle_on          = 1'b1;
        pcm.valid        = 1'b0;
        pcm.sample_left  = '0;
        pcm.sample_right = '0;
        pcm.start_flag   = 1'b0;
        cfg.valid        = 1'b0;
        cfg.index        = '0;
        cfg.data         = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Register defaults with no fade pending: mono, unity gain, one output per word.
        send_frame(16'h7FFF, 16'h8000, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b0);
        send_frame(16'hFFFF, 16'h0001, 1'b0);
        send_frame(16'h0000, 16'h5555, 1'b0);

        // Smallest step: 64 frames per word across full-scale swings.
        apply_settings(21'd1024, 21'd1, CFG_DATA_W'(UNITY_GAIN));
        send_frame(16'h7FFF, 16'h8000, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b0);

        // Steps below the floor are clamped to it.
        apply_settings(21'd0, 21'd1, CFG_DATA_W'(UNITY_GAIN));
        send_frame(16'h1234, 16'hEDCC, 1'b0);
        apply_settings(21'd1000, 21'd1, CFG_DATA_W'(UNITY_GAIN));
        send_frame(pick_sample(), pick_sample(), 1'b0);

        // Largest steps: most words yield nothing. Upper data bits lie outside the registers.
        apply_settings(21'h1FFFFF, 21'd1, 21'h1FB039);
        repeat (5) send_frame(pick_sample(), pick_sample(), 1'b0);
        apply_settings(21'd1572864, 21'h1FFFFE, CFG_DATA_W'(UNITY_GAIN));
        repeat (3) send_frame(pick_sample(), pick_sample(), 1'b0);

        // Start of play with fade-in, across the gain extremes.
        apply_settings(21'd40000, 21'd1, 21'd0);
        send_frame(16'h7FFF, 16'h8000, 1'b1);
        send_frame(16'h8000, 16'h7FFF, 1'b0);
        send_frame(16'h7FFF, 16'h8001, 1'b0);
        apply_settings(21'd40000, 21'd1, 21'd1);
        send_frame(16'h8000, 16'h7FFF, 1'b0);
        send_frame(16'hFFFF, 16'h0001, 1'b1);
        apply_settings(21'd40000, 21'd1, 21'd16384);
        send_frame(16'h8000, 16'h7FFF, 1'b0);
        apply_settings(21'd40000, 21'd1, 21'd32766);
        send_frame(16'h0001, 16'hFFFF, 1'b0);
        apply_settings(21'd65553, 21'd0, CFG_DATA_W'(UNITY_GAIN));
        send_frame(16'h7FFF, 16'h1234, 1'b1);
        send_frame(16'h8000, 16'h4321, 1'b0);

        random_play(35, 0, 1'b1);
        random_play(35, 0, 1'b0);
        random_play(35, 10, 1'b0);
        random_play(35, 6, 1'b0);
        idle_on = 1'b0;
        random_play(35, 10, 1'b0);

        drain_and_pause();
        if (frame_book.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
